### hdl/conv_layer_bias_relu_macros.svh
// ----------------------------------------------------------------------------
// conv_layer_bias_relu assertion macros
// Shorthand for clocked, reset-qualified assertions used by the checker.
// ----------------------------------------------------------------------------
`ifndef CONV_LAYER_BIAS_RELU_MACROS_SVH
`define CONV_LAYER_BIAS_RELU_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CVL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CVL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/cvl_pkg.sv
// ----------------------------------------------------------------------------
// cvl_pkg
// Shared constants, types and address functions of the convolution engine.
// ----------------------------------------------------------------------------
package cvl_pkg;

    // Store dimensions
    localparam int MAX_GRID   = 32;
    localparam int MAX_IN_CH  = 32;
    localparam int MAX_OUT_CH = 32;
    localparam int MAX_KERNEL = 8;

    // Fixed field widths
    localparam int FIELD_W = 5;
    localparam int TAP_W   = 3;
    localparam int VAL_W   = 16;
    localparam int FRAC_W  = 8;

    // Configuration register widths
    localparam int GRID_REG_W   = 6;
    localparam int CH_REG_W     = 6;
    localparam int KERNEL_REG_W = 4;
    localparam int STRIDE_REG_W = 3;
    localparam int BORDER_REG_W = 4;
    localparam int CFG_DATA_W   = 6;
    localparam int CFG_IDX_W    = 3;

    // Configuration reset values
    localparam int RST_GRID   = 23;
    localparam int RST_CH     = 5;
    localparam int RST_KERNEL = 5;
    localparam int RST_STRIDE = 1;
    localparam int RST_BORDER = 2;

    // Index widths into the stores
    localparam int GRID_IW = (MAX_GRID > 1)   ? $clog2(MAX_GRID)   : 1;
    localparam int CH_IW   = (MAX_IN_CH > 1)  ? $clog2(MAX_IN_CH)  : 1;
    localparam int OC_IW   = (MAX_OUT_CH > 1) ? $clog2(MAX_OUT_CH) : 1;
    localparam int K_IW    = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;

    // Count widths (hold the maximum itself)
    localparam int GRID_CW = $clog2(MAX_GRID + 1);
    localparam int CH_CW   = $clog2(MAX_IN_CH + 1);
    localparam int K_CW    = $clog2(MAX_KERNEL + 1);

    localparam int ACT_DEPTH  = MAX_GRID * MAX_GRID * MAX_IN_CH;
    localparam int WGT_DEPTH  = MAX_KERNEL * MAX_KERNEL * MAX_IN_CH * MAX_OUT_CH;
    localparam int BIAS_DEPTH = MAX_OUT_CH;
    localparam int ACT_AW     = $clog2(ACT_DEPTH);
    localparam int WGT_AW     = $clog2(WGT_DEPTH);
    localparam int BIAS_AW    = OC_IW;

    // Strided base position: stride times offset into the interior
    localparam int BASE_W = STRIDE_REG_W + FIELD_W;

    // Arithmetic
    localparam int PROD_W     = 2 * VAL_W;
    localparam int ACC_W      = 48;
    localparam int ROUND_HALF = 1 << (FRAC_W - 1);
    localparam logic signed [VAL_W-1:0] Q88_MAX = {1'b0, {(VAL_W-1){1'b1}}};

    typedef enum logic [1:0] {
        REQ_ACT_WR,
        REQ_WGT_WR,
        REQ_BIAS_WR,
        REQ_COMPUTE
    } req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_ROWS,
        CFG_GRID_COLS,
        CFG_IN_CHANNELS,
        CFG_KERNEL_ROWS,
        CFG_KERNEL_COLS,
        CFG_STRIDE_ROWS,
        CFG_STRIDE_COLS,
        CFG_BORDER_WIDTH
    } cfg_idx_t;

    // Clamped loop geometry handed to the sequencer
    typedef struct packed {
        logic [GRID_CW-1:0] gr;
        logic [GRID_CW-1:0] gc;
        logic [CH_CW-1:0]   icn;
        logic [K_CW-1:0]    kr;
        logic [K_CW-1:0]    kc;
    } geom_t;

    // One tap issued to the memories
    typedef struct packed {
        logic valid;
        logic keep;
        logic last;
    } tap_t;

    function automatic logic [ACT_AW-1:0] act_addr(
        input logic [GRID_IW-1:0] r,
        input logic [GRID_IW-1:0] c,
        input logic [CH_IW-1:0]   ch
    );
        logic [31:0] idx;
        idx = (32'(r) * MAX_GRID + 32'(c)) * MAX_IN_CH + 32'(ch);
        return idx[ACT_AW-1:0];
    endfunction

    function automatic logic [WGT_AW-1:0] wgt_addr(
        input logic [K_IW-1:0]  tr,
        input logic [K_IW-1:0]  tc,
        input logic [CH_IW-1:0] ic,
        input logic [OC_IW-1:0] oc
    );
        logic [31:0] idx;
        idx = ((32'(tr) * MAX_KERNEL + 32'(tc)) * MAX_IN_CH + 32'(ic)) * MAX_OUT_CH + 32'(oc);
        return idx[WGT_AW-1:0];
    endfunction

endpackage

### hdl/conv_layer_bias_relu.sv
// ----------------------------------------------------------------------------
// conv_layer_bias_relu
// Convolution layer engine with per-output-channel bias and ReLU, Q8.8.
// ----------------------------------------------------------------------------
// Requests arrive on one valid/ready channel. Activation, weight and bias
// writes land in three synchronous memories and complete in the cycle of
// their transfer; they produce no result. A compute request walks every
// kernel tap and input channel through one multiply-accumulate per cycle,
// fed by the single read port of the activation and weight memories, so it
// holds the engine for its walk of N taps and until its result is loaded,
// N = kernel_rows * kernel_cols * in_channels after clamping to the store
// sizes. A border-band position, an out-of-range output channel or an empty
// kernel issues one dummy tap instead of the walk. The result goes to an
// output register, so a new request is taken while the last result still
// waits on out_ready. Stores are undefined until written: there is no
// clearing pass after reset and the block is ready as soon as reset is
// released. Configuration writes belong in idle periods only.
// ----------------------------------------------------------------------------
module conv_layer_bias_relu (
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [1:0]                            req_type,
    input  logic [cvl_pkg::FIELD_W-1:0]           row,
    input  logic [cvl_pkg::FIELD_W-1:0]           col,
    input  logic [cvl_pkg::FIELD_W-1:0]           in_channel,
    input  logic [cvl_pkg::FIELD_W-1:0]           out_channel,
    input  logic [cvl_pkg::TAP_W-1:0]             tap_row,
    input  logic [cvl_pkg::TAP_W-1:0]             tap_col,
    input  logic signed [cvl_pkg::VAL_W-1:0]      value,

    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [cvl_pkg::FIELD_W-1:0]           out_row,
    output logic [cvl_pkg::FIELD_W-1:0]           out_col,
    output logic [cvl_pkg::FIELD_W-1:0]           out_chan,
    output logic signed [cvl_pkg::VAL_W-1:0]      result_value,
    output logic                                  saturated,

    input  logic                                  cfg_we,
    input  logic [cvl_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [cvl_pkg::CFG_DATA_W-1:0]        cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUSY,
        ST_HOLD
    } state_t;

    localparam int GEO_W = 8;

    // Configuration registers
    logic [cvl_pkg::GRID_REG_W-1:0]   grid_rows_reg;
    logic [cvl_pkg::GRID_REG_W-1:0]   grid_cols_reg;
    logic [cvl_pkg::CH_REG_W-1:0]     in_channels_reg;
    logic [cvl_pkg::KERNEL_REG_W-1:0] kernel_rows_reg;
    logic [cvl_pkg::KERNEL_REG_W-1:0] kernel_cols_reg;
    logic [cvl_pkg::STRIDE_REG_W-1:0] stride_rows_reg;
    logic [cvl_pkg::STRIDE_REG_W-1:0] stride_cols_reg;
    logic [cvl_pkg::BORDER_REG_W-1:0] border_width_reg;

    // Request control and echo
    state_t                           state_reg;
    logic [cvl_pkg::FIELD_W-1:0]      req_row_reg;
    logic [cvl_pkg::FIELD_W-1:0]      req_col_reg;
    logic [cvl_pkg::FIELD_W-1:0]      req_oc_reg;

    // Output register
    logic                             out_valid_reg;
    logic [cvl_pkg::FIELD_W-1:0]      out_row_reg;
    logic [cvl_pkg::FIELD_W-1:0]      out_col_reg;
    logic [cvl_pkg::FIELD_W-1:0]      out_chan_reg;
    logic signed [cvl_pkg::VAL_W-1:0] out_value_reg;
    logic                             out_sat_reg;

    logic                             in_xfer;
    logic                             start;
    logic                             slot_free;
    cvl_pkg::geom_t                   geom;
    logic [GEO_W-1:0]                 row_ext;
    logic [GEO_W-1:0]                 col_ext;
    logic [GEO_W-1:0]                 border_ext;
    logic                             zero_case;
    logic                             empty;
    logic [cvl_pkg::FIELD_W-1:0]      row_off;
    logic [cvl_pkg::FIELD_W-1:0]      col_off;
    logic [cvl_pkg::BASE_W-1:0]       base_row;
    logic [cvl_pkg::BASE_W-1:0]       base_col;

    logic                             act_we;
    logic                             wgt_we;
    logic                             bias_we;
    logic [cvl_pkg::ACT_AW-1:0]       act_rd_addr;
    logic [cvl_pkg::WGT_AW-1:0]       wgt_rd_addr;
    logic [cvl_pkg::VAL_W-1:0]        act_rd_data;
    logic [cvl_pkg::VAL_W-1:0]        wgt_rd_data;
    logic [cvl_pkg::VAL_W-1:0]        bias_rd_data;
    cvl_pkg::tap_t                    issue;
    logic                             mac_done;
    logic signed [cvl_pkg::VAL_W-1:0] mac_result;
    logic                             mac_sat;

    // Only the idle state takes a request; the memories therefore never see
    // a write and a read of the same entry in flight together.
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign start     = in_xfer && (req_type == cvl_pkg::REQ_COMPUTE);
    assign slot_free = !out_valid_reg || out_ready;

    // Clamp register values to the store sizes
    assign geom.gr  = (int'(grid_rows_reg) > cvl_pkg::MAX_GRID)
                      ? cvl_pkg::GRID_CW'(cvl_pkg::MAX_GRID)
                      : cvl_pkg::GRID_CW'(grid_rows_reg);
    assign geom.gc  = (int'(grid_cols_reg) > cvl_pkg::MAX_GRID)
                      ? cvl_pkg::GRID_CW'(cvl_pkg::MAX_GRID)
                      : cvl_pkg::GRID_CW'(grid_cols_reg);
    assign geom.icn = (int'(in_channels_reg) > cvl_pkg::MAX_IN_CH)
                      ? cvl_pkg::CH_CW'(cvl_pkg::MAX_IN_CH)
                      : cvl_pkg::CH_CW'(in_channels_reg);
    assign geom.kr  = (int'(kernel_rows_reg) > cvl_pkg::MAX_KERNEL)
                      ? cvl_pkg::K_CW'(cvl_pkg::MAX_KERNEL)
                      : cvl_pkg::K_CW'(kernel_rows_reg);
    assign geom.kc  = (int'(kernel_cols_reg) > cvl_pkg::MAX_KERNEL)
                      ? cvl_pkg::K_CW'(cvl_pkg::MAX_KERNEL)
                      : cvl_pkg::K_CW'(kernel_cols_reg);

    // Border band, outside-grid positions and bad output channels give 0
    assign row_ext    = GEO_W'(row);
    assign col_ext    = GEO_W'(col);
    assign border_ext = GEO_W'(border_width_reg);
    assign zero_case  = (int'(out_channel) >= cvl_pkg::MAX_OUT_CH)
                     || (row_ext < border_ext)
                     || (col_ext < border_ext)
                     || (row_ext + border_ext >= GEO_W'(geom.gr))
                     || (col_ext + border_ext >= GEO_W'(geom.gc));
    assign empty      = zero_case || (geom.kr == '0) || (geom.kc == '0) || (geom.icn == '0);

    // Top-left input position of the window
    assign row_off  = row - cvl_pkg::FIELD_W'(border_width_reg);
    assign col_off  = col - cvl_pkg::FIELD_W'(border_width_reg);
    assign base_row = cvl_pkg::BASE_W'(stride_rows_reg) * cvl_pkg::BASE_W'(row_off);
    assign base_col = cvl_pkg::BASE_W'(stride_cols_reg) * cvl_pkg::BASE_W'(col_off);

    // Drop writes that fall outside a store
    assign act_we  = in_xfer && (req_type == cvl_pkg::REQ_ACT_WR)
                  && (int'(row) < cvl_pkg::MAX_GRID) && (int'(col) < cvl_pkg::MAX_GRID)
                  && (int'(in_channel) < cvl_pkg::MAX_IN_CH);
    assign wgt_we  = in_xfer && (req_type == cvl_pkg::REQ_WGT_WR)
                  && (int'(tap_row) < cvl_pkg::MAX_KERNEL)
                  && (int'(tap_col) < cvl_pkg::MAX_KERNEL)
                  && (int'(in_channel) < cvl_pkg::MAX_IN_CH)
                  && (int'(out_channel) < cvl_pkg::MAX_OUT_CH);
    assign bias_we = in_xfer && (req_type == cvl_pkg::REQ_BIAS_WR)
                  && (int'(out_channel) < cvl_pkg::MAX_OUT_CH);

    cvl_ram #(
        .DEPTH (cvl_pkg::ACT_DEPTH),
        .WIDTH (cvl_pkg::VAL_W),
        .AW    (cvl_pkg::ACT_AW)
    ) u_act_ram (
        .clk     (clk),
        .wr_en   (act_we),
        .wr_addr (cvl_pkg::act_addr(cvl_pkg::GRID_IW'(row), cvl_pkg::GRID_IW'(col),
                                    cvl_pkg::CH_IW'(in_channel))),
        .wr_data (value),
        .rd_en   (issue.valid),
        .rd_addr (act_rd_addr),
        .rd_data (act_rd_data)
    );

    cvl_ram #(
        .DEPTH (cvl_pkg::WGT_DEPTH),
        .WIDTH (cvl_pkg::VAL_W),
        .AW    (cvl_pkg::WGT_AW)
    ) u_wgt_ram (
        .clk     (clk),
        .wr_en   (wgt_we),
        .wr_addr (cvl_pkg::wgt_addr(cvl_pkg::K_IW'(tap_row), cvl_pkg::K_IW'(tap_col),
                                    cvl_pkg::CH_IW'(in_channel),
                                    cvl_pkg::OC_IW'(out_channel))),
        .wr_data (value),
        .rd_en   (issue.valid),
        .rd_addr (wgt_rd_addr),
        .rd_data (wgt_rd_data)
    );

    // Bias is read once at the compute transfer and held until the next one
    cvl_ram #(
        .DEPTH (cvl_pkg::BIAS_DEPTH),
        .WIDTH (cvl_pkg::VAL_W),
        .AW    (cvl_pkg::BIAS_AW)
    ) u_bias_ram (
        .clk     (clk),
        .wr_en   (bias_we),
        .wr_addr (cvl_pkg::BIAS_AW'(out_channel)),
        .wr_data (value),
        .rd_en   (start),
        .rd_addr (cvl_pkg::BIAS_AW'(out_channel)),
        .rd_data (bias_rd_data)
    );

    cvl_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .empty       (empty),
        .geom        (geom),
        .base_row    (base_row),
        .base_col    (base_col),
        .oc          (out_channel),
        .act_rd_addr (act_rd_addr),
        .wgt_rd_addr (wgt_rd_addr),
        .issue       (issue)
    );

    cvl_mac u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .force_zero (zero_case),
        .issue      (issue),
        .act_data   (act_rd_data),
        .wgt_data   (wgt_rd_data),
        .bias_data  (bias_rd_data),
        .done       (mac_done),
        .result     (mac_result),
        .saturated  (mac_sat)
    );

    // Configuration writes, truncated to each register's width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg    <= cvl_pkg::GRID_REG_W'(cvl_pkg::RST_GRID);
            grid_cols_reg    <= cvl_pkg::GRID_REG_W'(cvl_pkg::RST_GRID);
            in_channels_reg  <= cvl_pkg::CH_REG_W'(cvl_pkg::RST_CH);
            kernel_rows_reg  <= cvl_pkg::KERNEL_REG_W'(cvl_pkg::RST_KERNEL);
            kernel_cols_reg  <= cvl_pkg::KERNEL_REG_W'(cvl_pkg::RST_KERNEL);
            stride_rows_reg  <= cvl_pkg::STRIDE_REG_W'(cvl_pkg::RST_STRIDE);
            stride_cols_reg  <= cvl_pkg::STRIDE_REG_W'(cvl_pkg::RST_STRIDE);
            border_width_reg <= cvl_pkg::BORDER_REG_W'(cvl_pkg::RST_BORDER);
        end
        else if (cfg_we)
        begin
            unique case (cvl_pkg::cfg_idx_t'(cfg_index))
                cvl_pkg::CFG_GRID_ROWS:
                    grid_rows_reg <= cvl_pkg::GRID_REG_W'(cfg_data);
                cvl_pkg::CFG_GRID_COLS:
                    grid_cols_reg <= cvl_pkg::GRID_REG_W'(cfg_data);
                cvl_pkg::CFG_IN_CHANNELS:
                    in_channels_reg <= cvl_pkg::CH_REG_W'(cfg_data);
                cvl_pkg::CFG_KERNEL_ROWS:
                    kernel_rows_reg <= cvl_pkg::KERNEL_REG_W'(cfg_data);
                cvl_pkg::CFG_KERNEL_COLS:
                    kernel_cols_reg <= cvl_pkg::KERNEL_REG_W'(cfg_data);
                cvl_pkg::CFG_STRIDE_ROWS:
                    stride_rows_reg <= cvl_pkg::STRIDE_REG_W'(cfg_data);
                cvl_pkg::CFG_STRIDE_COLS:
                    stride_cols_reg <= cvl_pkg::STRIDE_REG_W'(cfg_data);
                cvl_pkg::CFG_BORDER_WIDTH:
                    border_width_reg <= cvl_pkg::BORDER_REG_W'(cfg_data);
            endcase
        end
    end

    // Hold the position of the running compute for the result echo
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            req_row_reg <= row;
            req_col_reg <= col;
            req_oc_reg  <= out_channel;
        end
    end

    // Request state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            out_chan_reg  <= '0;
            out_value_reg <= '0;
            out_sat_reg   <= 1'b0;
        end
        else
        begin
            if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= ST_BUSY;
                    end
                end
                ST_BUSY, ST_HOLD:
                begin
                    // Load the result once the output register frees up
                    if ((state_reg == ST_HOLD) || mac_done)
                    begin
                        if (slot_free)
                        begin
                            out_valid_reg <= 1'b1;
                            out_row_reg   <= req_row_reg;
                            out_col_reg   <= req_col_reg;
                            out_chan_reg  <= req_oc_reg;
                            out_value_reg <= mac_result;
                            out_sat_reg   <= mac_sat;
                            state_reg     <= ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_HOLD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_row      = out_row_reg;
    assign out_col      = out_col_reg;
    assign out_chan     = out_chan_reg;
    assign result_value = out_value_reg;
    assign saturated    = out_sat_reg;

endmodule

### hdl/cvl_ram.sv
// ----------------------------------------------------------------------------
// cvl_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cvl_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/cvl_seq.sv
// ----------------------------------------------------------------------------
// cvl_seq
// Tap sequencer: walks kernel rows, kernel columns and input channels, one
// tap per cycle, and drives the activation and weight read addresses.
// ----------------------------------------------------------------------------
module cvl_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        empty,
    input  cvl_pkg::geom_t              geom,
    input  logic [cvl_pkg::BASE_W-1:0]  base_row,
    input  logic [cvl_pkg::BASE_W-1:0]  base_col,
    input  logic [cvl_pkg::FIELD_W-1:0] oc,
    output logic [cvl_pkg::ACT_AW-1:0]  act_rd_addr,
    output logic [cvl_pkg::WGT_AW-1:0]  wgt_rd_addr,
    output cvl_pkg::tap_t               issue
);

    logic                        run_reg;
    logic                        dummy_reg;
    logic [cvl_pkg::K_CW-1:0]    di_reg;
    logic [cvl_pkg::K_CW-1:0]    dj_reg;
    logic [cvl_pkg::CH_CW-1:0]   ch_reg;
    cvl_pkg::geom_t              geom_reg;
    logic [cvl_pkg::BASE_W-1:0]  base_row_reg;
    logic [cvl_pkg::BASE_W-1:0]  base_col_reg;
    logic [cvl_pkg::FIELD_W-1:0] oc_reg;

    logic [cvl_pkg::BASE_W:0] in_row;
    logic [cvl_pkg::BASE_W:0] in_col;
    logic                     row_ok;
    logic                     col_ok;
    logic                     ch_last;
    logic                     dj_last;
    logic                     di_last;

    assign in_row  = (cvl_pkg::BASE_W + 1)'(base_row_reg) + (cvl_pkg::BASE_W + 1)'(di_reg);
    assign in_col  = (cvl_pkg::BASE_W + 1)'(base_col_reg) + (cvl_pkg::BASE_W + 1)'(dj_reg);
    assign row_ok  = in_row < (cvl_pkg::BASE_W + 1)'(geom_reg.gr);
    assign col_ok  = in_col < (cvl_pkg::BASE_W + 1)'(geom_reg.gc);
    assign ch_last = ch_reg == cvl_pkg::CH_CW'(geom_reg.icn - cvl_pkg::CH_CW'(1));
    assign dj_last = dj_reg == cvl_pkg::K_CW'(geom_reg.kc - cvl_pkg::K_CW'(1));
    assign di_last = di_reg == cvl_pkg::K_CW'(geom_reg.kr - cvl_pkg::K_CW'(1));

    // An empty sum still sends one dummy tap so the MAC sees a last marker
    assign issue.valid = run_reg | dummy_reg;
    assign issue.keep  = run_reg & row_ok & col_ok;
    assign issue.last  = dummy_reg | (ch_last & dj_last & di_last);

    assign act_rd_addr = cvl_pkg::act_addr(in_row[cvl_pkg::GRID_IW-1:0],
                                           in_col[cvl_pkg::GRID_IW-1:0],
                                           ch_reg[cvl_pkg::CH_IW-1:0]);
    assign wgt_rd_addr = cvl_pkg::wgt_addr(di_reg[cvl_pkg::K_IW-1:0],
                                           dj_reg[cvl_pkg::K_IW-1:0],
                                           ch_reg[cvl_pkg::CH_IW-1:0],
                                           cvl_pkg::OC_IW'(oc_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            dummy_reg <= 1'b0;
            di_reg    <= '0;
            dj_reg    <= '0;
            ch_reg    <= '0;
        end
        else
        begin
            dummy_reg <= start & empty;
            if (start)
            begin
                run_reg <= !empty;
                di_reg  <= '0;
                dj_reg  <= '0;
                ch_reg  <= '0;
            end
            else if (run_reg)
            begin
                if (ch_last)
                begin
                    ch_reg <= '0;
                    if (dj_last)
                    begin
                        dj_reg <= '0;
                        if (di_last)
                        begin
                            di_reg  <= '0;
                            run_reg <= 1'b0;
                        end
                        else
                        begin
                            di_reg <= di_reg + cvl_pkg::K_CW'(1);
                        end
                    end
                    else
                    begin
                        dj_reg <= dj_reg + cvl_pkg::K_CW'(1);
                    end
                end
                else
                begin
                    ch_reg <= ch_reg + cvl_pkg::CH_CW'(1);
                end
            end
        end
    end

    // Hold the request geometry for the whole walk
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            geom_reg     <= geom;
            base_row_reg <= base_row;
            base_col_reg <= base_col;
            oc_reg       <= oc;
        end
    end

endmodule

### hdl/cvl_mac.sv
// ----------------------------------------------------------------------------
// cvl_mac
// Multiply-accumulate datapath: product register, wide accumulator, bias add,
// ReLU, rounding and saturation to Q8.8.
// ----------------------------------------------------------------------------
module cvl_mac (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic                             force_zero,
    input  cvl_pkg::tap_t                    issue,
    input  logic signed [cvl_pkg::VAL_W-1:0] act_data,
    input  logic signed [cvl_pkg::VAL_W-1:0] wgt_data,
    input  logic signed [cvl_pkg::VAL_W-1:0] bias_data,
    output logic                             done,
    output logic signed [cvl_pkg::VAL_W-1:0] result,
    output logic                             saturated
);

    typedef enum logic [1:0] {
        M_IDLE,
        M_ACC,
        M_BIAS,
        M_ROUND
    } mac_state_t;

    mac_state_t                        state_reg;
    cvl_pkg::tap_t                     tap1_reg;
    cvl_pkg::tap_t                     tap2_reg;
    logic signed [cvl_pkg::PROD_W-1:0] prod_reg;
    logic signed [cvl_pkg::PROD_W-1:0] prod_next;
    logic signed [cvl_pkg::ACC_W-1:0]  acc_reg;
    logic                              zero_reg;
    logic                              done_reg;
    logic signed [cvl_pkg::VAL_W-1:0]  result_reg;
    logic                              sat_reg;

    logic signed [cvl_pkg::PROD_W-1:0] act_ext;
    logic signed [cvl_pkg::PROD_W-1:0] wgt_ext;
    logic signed [cvl_pkg::ACC_W-1:0]  prod_acc;
    logic signed [cvl_pkg::ACC_W-1:0]  bias_acc;
    logic [cvl_pkg::ACC_W-1:0]         rnd_sum;
    logic                              acc_pos;
    logic                              over;

    assign act_ext   = cvl_pkg::PROD_W'(act_data);
    assign wgt_ext   = cvl_pkg::PROD_W'(wgt_data);
    assign prod_next = tap1_reg.keep ? act_ext * wgt_ext : '0;

    assign prod_acc = {{(cvl_pkg::ACC_W - cvl_pkg::PROD_W){prod_reg[cvl_pkg::PROD_W-1]}},
                       prod_reg};
    assign bias_acc = {{(cvl_pkg::ACC_W - cvl_pkg::VAL_W - cvl_pkg::FRAC_W)
                        {bias_data[cvl_pkg::VAL_W-1]}},
                       bias_data, cvl_pkg::FRAC_W'(0)};

    // Round to nearest with ties upward; anything above the Q8.8 top clips
    assign acc_pos = !acc_reg[cvl_pkg::ACC_W-1] && (acc_reg != '0);
    assign rnd_sum = acc_reg + cvl_pkg::ACC_W'(cvl_pkg::ROUND_HALF);
    assign over    = |rnd_sum[cvl_pkg::ACC_W-1:cvl_pkg::FRAC_W+cvl_pkg::VAL_W-1];

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= M_IDLE;
            tap1_reg   <= '0;
            tap2_reg   <= '0;
            acc_reg    <= '0;
            zero_reg   <= 1'b0;
            done_reg   <= 1'b0;
            result_reg <= '0;
            sat_reg    <= 1'b0;
        end
        else
        begin
            tap1_reg <= issue;
            tap2_reg <= tap1_reg;
            done_reg <= 1'b0;
            unique case (state_reg)
                M_IDLE:
                begin
                    if (start)
                    begin
                        acc_reg   <= '0;
                        zero_reg  <= force_zero;
                        state_reg <= M_ACC;
                    end
                end
                M_ACC:
                begin
                    if (tap2_reg.valid)
                    begin
                        acc_reg <= acc_reg + prod_acc;
                        if (tap2_reg.last)
                        begin
                            state_reg <= M_BIAS;
                        end
                    end
                end
                M_BIAS:
                begin
                    acc_reg   <= acc_reg + bias_acc;
                    state_reg <= M_ROUND;
                end
                M_ROUND:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= M_IDLE;
                    if (zero_reg || !acc_pos)
                    begin
                        result_reg <= '0;
                        sat_reg    <= 1'b0;
                    end
                    else if (over)
                    begin
                        result_reg <= cvl_pkg::Q88_MAX;
                        sat_reg    <= 1'b1;
                    end
                    else
                    begin
                        result_reg <= {1'b0,
                            rnd_sum[cvl_pkg::FRAC_W+cvl_pkg::VAL_W-2:cvl_pkg::FRAC_W]};
                        sat_reg    <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

    assign done      = done_reg;
    assign result    = result_reg;
    assign saturated = sat_reg;

endmodule

### hdl/cvl_checker.sv
// ----------------------------------------------------------------------------
// cvl_checker
// Port-level checks on the convolution engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "conv_layer_bias_relu_macros.svh"

module cvl_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic [1:0]                       req_type,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic signed [cvl_pkg::VAL_W-1:0] result_value,
    input logic                             saturated
);

    // A result waits until it is taken
    `CVL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")

    // Store writes finish in their own cycle
    `CVL_ASSERT_NEXT(a_write_quick, clk, rst_n, in_valid && in_ready && (req_type != cvl_pkg::REQ_COMPUTE), in_ready, "engine busy after a write")

    // A compute occupies the engine
    `CVL_ASSERT_NEXT(a_compute_busy, clk, rst_n, in_valid && in_ready && (req_type == cvl_pkg::REQ_COMPUTE), !in_ready, "engine idle right after a compute transfer")

    // Clipping only ever lands on the Q8.8 top
    `CVL_ASSERT_SAME(a_sat_value, clk, rst_n, out_valid && saturated, result_value == cvl_pkg::Q88_MAX, "saturated result not at the top value")

    // ReLU output is never negative
    `CVL_ASSERT_SAME(a_relu_sign, clk, rst_n, out_valid, !result_value[cvl_pkg::VAL_W-1], "negative result after ReLU")

endmodule

bind conv_layer_bias_relu cvl_checker u_cvl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_value (result_value),
    .saturated    (saturated)
);
